// ===== hw/rtl/wfrm_pkg.sv =====
// Shared constants and codes for the windowed frame rate meter.
`default_nettype none

package wfrm_pkg;

  // Window and datapath sizing
  localparam int WINDOW_DEPTH  = 256;
  localparam int DURATION_BITS = 32;
  localparam int IDX_W         = $clog2(WINDOW_DEPTH);
  localparam int CNT_W         = IDX_W + 1;
  localparam int SUM_W         = DURATION_BITS + IDX_W;
  localparam int TS_W          = 48;
  localparam int TPS_W         = 16;
  localparam int FRAC_W        = 16;
  localparam int RATE_W        = 34;
  localparam int NUM_W         = TPS_W + CNT_W + FRAC_W;
  localparam int MODE_W        = 2;

  // Stream word packing
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  // Register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_TPS   = 1'b0;
  localparam logic [TPS_W-1:0]     TPS_RESET = 16'd1000;

  // Event codes carried in tuser
  localparam logic [MODE_W-1:0] MODE_ENTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEAVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [DURATION_BITS-1:0] DUR_MAX  = '1;
  localparam logic [RATE_W-1:0]        RATE_MAX = '1;

endpackage

`default_nettype wire

// ===== hw/rtl/wfrm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module wfrm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wfrm_pkg::NUM_W-1:0]  num_i,
  input  logic [wfrm_pkg::SUM_W-1:0]  den_i,
  output logic                        done_o,
  output logic [wfrm_pkg::NUM_W-1:0]  quo_o
);
  import wfrm_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  den_q, den_d;
  logic [NUM_W-1:0]  nq_q, nq_d;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              fits;

  // One trial subtraction per cycle; numerator bits shift out at the top
  // while quotient bits shift in at the bottom of the same register.
  assign trial = {rem_q, nq_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    nq_d   = nq_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      den_d  = den_i;
      nq_d   = num_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      nq_d   = {nq_q[NUM_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    nq_q  <= nq_d;
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

`default_nettype wire

// ===== hw/rtl/windowed_frame_rate_meter.sv =====
// Frame rate meter: frame durations in a ring, moving-average rate on query.
// Enter, unmatched leave and most queries: straight from accept to emit.
// Matched leave: ring read, subtract oldest, add newest, emit.
// Query over a non-empty window with nonzero sum: multiply, then the
// bit-serial divider (one of 41 quotient bits per cycle), then emit. One word at a time.
// Async active-low reset clears control state and sets ticks_per_second to 1000.
`default_nettype none

module windowed_frame_rate_meter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [wfrm_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // [47:0] now_ticks
  input  logic [wfrm_pkg::MODE_W-1:0]         s_axis_tuser_i,  // [1:0] mode
  // result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [wfrm_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,  // [33:0] rate_q16
  output logic [wfrm_pkg::OUT_USER_W-1:0]     m_axis_tuser_o,  // [0] status, [1] rate_infinite
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wfrm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [wfrm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wfrm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import wfrm_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [TPS_W-1:0]         tps_q;
  logic                     running_q, running_d;
  logic [TS_W-1:0]          start_q, start_d;
  logic [IDX_W-1:0]         widx_q, widx_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic [DURATION_BITS-1:0] dur_q, dur_d;
  logic                     res_status_q, res_status_d;
  logic [RATE_W-1:0]        res_rate_q, res_rate_d;
  logic                     res_inf_q, res_inf_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_status_q, out_inf_q;
  logic [RATE_W-1:0]        out_rate_q;
  logic                     out_load;

  logic [DURATION_BITS-1:0] ring_mem [WINDOW_DEPTH];
  logic [DURATION_BITS-1:0] ring_rd_q;
  logic                     ring_we;

  logic                     in_acc;
  logic                     full;
  logic [TS_W-1:0]          elapsed;
  logic [DURATION_BITS-1:0] elapsed_sat;
  logic                     div_start;
  logic [TPS_W+CNT_W-1:0]   num_prod;
  logic [NUM_W-1:0]         div_num;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;
  logic [RATE_W-1:0]        quo_sat;
  logic                     reg_wr;

  // Register port: always ready, word-aligned decode
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_TPS);
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_TPS) ?
                  {{(APB_DATA_W-TPS_W){1'b0}}, tps_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (reg_wr) begin
      tps_q <= pwdata[TPS_W-1:0];
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CNT_W'(WINDOW_DEPTH));

  // Elapsed time modulo the timestamp range, clipped to the duration width
  assign elapsed     = s_axis_tdata_i[TS_W-1:0] - start_q;
  assign elapsed_sat = (elapsed[TS_W-1:DURATION_BITS] != '0) ? DUR_MAX
                                                             : elapsed[DURATION_BITS-1:0];

  // Numerator product is registered inside the divider
  assign num_prod = (TPS_W+CNT_W)'(tps_q) * (TPS_W+CNT_W)'(count_q);
  assign div_num  = {num_prod, {FRAC_W{1'b0}}};
  assign quo_sat  = (div_quo[NUM_W-1:RATE_W] != '0) ? RATE_MAX : div_quo[RATE_W-1:0];

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    running_d    = running_q;
    start_d      = start_q;
    widx_d       = widx_q;
    count_d      = count_q;
    sum_d        = sum_q;
    dur_d        = dur_q;
    res_status_d = res_status_q;
    res_rate_d   = res_rate_q;
    res_inf_d    = res_inf_q;
    ring_we      = 1'b0;
    div_start    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_status_d = 1'b0;
          res_rate_d   = '0;
          res_inf_d    = 1'b0;
          state_d      = S_EMIT;
          unique case (s_axis_tuser_i)
            MODE_ENTER: begin
              running_d = 1'b1;
              start_d   = s_axis_tdata_i[TS_W-1:0];
            end
            MODE_LEAVE: begin
              if (!running_q) begin
                res_status_d = 1'b1;
              end else begin
                dur_d   = elapsed_sat;
                state_d = S_SUB;
              end
            end
            MODE_QUERY: begin
              if (count_q == '0) begin
                res_rate_d = RATE_W'({tps_q, {FRAC_W{1'b0}}});
              end else if (sum_q == '0) begin
                res_rate_d = RATE_MAX;
                res_inf_d  = 1'b1;
              end else begin
                state_d = S_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SUB: begin
        // oldest entry leaves the window once it is full
        if (full) begin
          sum_d = sum_q - SUM_W'(ring_rd_q);
        end
        state_d = S_ADD;
      end
      S_ADD: begin
        sum_d     = sum_q + SUM_W'(dur_q);
        ring_we   = 1'b1;
        widx_d    = widx_q + 1'b1;
        count_d   = full ? count_q : count_q + 1'b1;
        running_d = 1'b0;
        state_d   = S_EMIT;
      end
      S_MUL: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_rate_d = quo_sat;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= 1'b0;
      start_q     <= '0;
      widx_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      start_q     <= start_d;
      widx_q      <= widx_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dur_q        <= dur_d;
    res_status_q <= res_status_d;
    res_rate_q   <= res_rate_d;
    res_inf_q    <= res_inf_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_rate_q   <= res_rate_q;
      out_inf_q    <= res_inf_q;
    end
  end

  // Duration ring: one write port, registered read at the write pointer
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[widx_q] <= dur_q;
    end
    ring_rd_q <= ring_mem[widx_q];
  end

  wfrm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_rate_q);
  assign m_axis_tuser_o  = {out_inf_q, out_status_q};

endmodule

`default_nettype wire
